// ===== rtl/gsbq_pkg.sv =====
package gsbq_pkg;

  // CORDIC vectoring iterations; the arctangent table below covers up to 23.
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITER_W           = $clog2(ANGLE_ITERATIONS);
  localparam int TBL_IDX_W        = 5;
  localparam int ATAN_W           = 22;

  // Angle datapath: degrees in Q16, wide enough for the CORDIC gain.
  localparam int CORDIC_W = 26;
  localparam int Q_SHIFT  = 16;
  localparam int DEG_W    = 9;
  localparam logic [DEG_W-1:0] MAX_DEGREES = DEG_W'(359);
  localparam logic signed [CORDIC_W-1:0] HALF_TURN_Q16 = CORDIC_W'(180 * 65536);
  localparam logic signed [CORDIC_W-1:0] FULL_TURN_Q16 = CORDIC_W'(360 * 65536);

  // (degrees * 65536) / 360 equals (degrees * 8192) / 45, done two bits a cycle.
  localparam int DIVIDEND_W = DEG_W + 13;
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int REM_W      = 6;
  localparam int CODE_W     = 16;
  localparam logic [REM_W+1:0] DIVISOR_X1 = (REM_W + 2)'(45);
  localparam logic [REM_W+1:0] DIVISOR_X2 = (REM_W + 2)'(90);
  localparam logic [REM_W+1:0] DIVISOR_X3 = (REM_W + 2)'(135);

  // Configuration register indexes (byte address divided by four).
  localparam logic [2:0] REG_INPUT_DISABLED = 3'd0;
  localparam logic [2:0] REG_DEADZONE_LOW   = 3'd1;
  localparam logic [2:0] REG_DEADZONE_HIGH  = 3'd2;
  localparam logic [2:0] REG_REPEAT_DELAY   = 3'd3;
  localparam logic [2:0] REG_REPEAT_RELOAD  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_ANGLE,
    S_LOAD
  } ctl_state_t;

  typedef enum logic [2:0] {
    ANG_IDLE,
    ANG_ROT,
    ANG_FIX,
    ANG_DIV,
    ANG_DONE
  } ang_state_t;

  typedef struct packed {
    logic              start;
    logic              bypass;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
  } ang_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
    logic [3:0]        sector;
  } ang_rsp_t;

  // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = ATAN_W'(2949120);
      5'd1:    v = ATAN_W'(1740967);
      5'd2:    v = ATAN_W'(919879);
      5'd3:    v = ATAN_W'(466945);
      5'd4:    v = ATAN_W'(234379);
      5'd5:    v = ATAN_W'(117304);
      5'd6:    v = ATAN_W'(58666);
      5'd7:    v = ATAN_W'(29335);
      5'd8:    v = ATAN_W'(14668);
      5'd9:    v = ATAN_W'(7334);
      5'd10:   v = ATAN_W'(3667);
      5'd11:   v = ATAN_W'(1833);
      5'd12:   v = ATAN_W'(917);
      5'd13:   v = ATAN_W'(458);
      5'd14:   v = ATAN_W'(229);
      5'd15:   v = ATAN_W'(115);
      5'd16:   v = ATAN_W'(57);
      5'd17:   v = ATAN_W'(29);
      5'd18:   v = ATAN_W'(14);
      5'd19:   v = ATAN_W'(7);
      5'd20:   v = ATAN_W'(4);
      5'd21:   v = ATAN_W'(2);
      5'd22:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Direction bits per 22.5 degree sector: 1 right, 2 up, 4 left, 8 down.
  function automatic logic [3:0] sector_dir(input logic [3:0] sector);
    logic [3:0] d;
    unique case (sector)
      4'd0, 4'd15:  d = 4'd1;
      4'd1, 4'd2:   d = 4'd3;
      4'd3, 4'd4:   d = 4'd2;
      4'd5, 4'd6:   d = 4'd6;
      4'd7, 4'd8:   d = 4'd4;
      4'd9, 4'd10:  d = 4'd12;
      4'd11, 4'd12: d = 4'd8;
      default:      d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/gsbq_angle.sv =====
module gsbq_angle (
  input  logic               clk,
  input  logic               rst,
  input  gsbq_pkg::ang_req_t req,
  output gsbq_pkg::ang_rsp_t rsp
);
  import gsbq_pkg::*;

  ang_state_t state, state_next;

  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] dx, dy, atan_ext, z_adj;
  logic signed [CORDIC_W-1:0] x_init, y_init, sx_ext, sy_ext;
  logic [ITER_W-1:0]          iter;
  logic                       bypass;
  logic [DEG_W-1:0]           deg_raw, deg;
  logic [DIVIDEND_W-1:0]      num;
  logic [REM_W-1:0]           rem, rem_next;
  logic [REM_W+1:0]           r_ext;
  logic [1:0]                 digit;
  logic [CODE_W-1:0]          quo;
  logic [STEP_W-1:0]          step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ANG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ANG_IDLE: begin
        if (req.start) state_next = ANG_ROT;
      end
      ANG_ROT: begin
        if (iter == ITER_W'(ANGLE_ITERATIONS - 1)) state_next = ANG_FIX;
      end
      ANG_FIX: state_next = ANG_DIV;
      ANG_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = ANG_DONE;
      end
      ANG_DONE: state_next = ANG_IDLE;
      default:  state_next = ANG_IDLE;
    endcase
  end

  always_comb begin
    sx_ext   = CORDIC_W'(req.sx) <<< Q_SHIFT;
    sy_ext   = CORDIC_W'(req.sy) <<< Q_SHIFT;
    x_init   = req.sx[7] ? -sx_ext : sx_ext;
    y_init   = req.sx[7] ? sy_ext : -sy_ext;
    dx       = y >>> iter;
    dy       = x >>> iter;
    atan_ext = {{(CORDIC_W - ATAN_W){1'b0}}, atan_q16(TBL_IDX_W'(iter))};
    z_adj    = z[CORDIC_W-1] ? z + FULL_TURN_Q16 : z;
    deg_raw  = z_adj[Q_SHIFT+DEG_W-1:Q_SHIFT];
    if (bypass) begin
      deg = '0;
    end else if (deg_raw > MAX_DEGREES) begin
      deg = MAX_DEGREES;
    end else begin
      deg = deg_raw;
    end
    r_ext = {rem, num[DIVIDEND_W-1 -: 2]};
    priority if (r_ext >= DIVISOR_X3) begin
      digit    = 2'd3;
      rem_next = REM_W'(r_ext - DIVISOR_X3);
    end else if (r_ext >= DIVISOR_X2) begin
      digit    = 2'd2;
      rem_next = REM_W'(r_ext - DIVISOR_X2);
    end else if (r_ext >= DIVISOR_X1) begin
      digit    = 2'd1;
      rem_next = REM_W'(r_ext - DIVISOR_X1);
    end else begin
      digit    = 2'd0;
      rem_next = r_ext[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ANG_IDLE: begin
        if (req.start) begin
          x      <= x_init;
          y      <= y_init;
          z      <= req.sx[7] ? HALF_TURN_Q16 : '0;
          bypass <= req.bypass;
          iter   <= '0;
        end
      end
      ANG_ROT: begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_ext;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_ext;
        end
        iter <= iter + 1'b1;
      end
      ANG_FIX: begin
        num  <= {deg, {(DIVIDEND_W - DEG_W){1'b0}}};
        rem  <= '0;
        quo  <= '0;
        step <= '0;
      end
      ANG_DIV: begin
        num  <= {num[DIVIDEND_W-3:0], 2'b00};
        rem  <= rem_next;
        quo  <= {quo[CODE_W-3:0], digit};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done   = (state == ANG_DONE);
  assign rsp.code   = quo;
  assign rsp.sector = quo[CODE_W-1 -: 4];

endmodule

// ===== rtl/gamepad_stick_and_button_qualifier.sv =====
// From an accepted request to the result register, a request passes the prepare
// state, the angle unit (16 CORDIC iterations, one fix-up, 11 two-bit
// division steps, one done state) and the load state.
// A new request is taken only in the idle state, once the last one has been
// loaded. A result still waiting only delays the load.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears the button history, repeat count, latches and result valid.
module gamepad_stick_and_button_qualifier (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        sample_valid,
  input  logic [17:0] raw_buttons,
  input  logic [7:0]  stick_raw_x,
  input  logic [7:0]  stick_raw_y,
  // Result channel.
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [19:0] combined_buttons,
  output logic [19:0] rising_edges,
  output logic [19:0] falling_edges,
  output logic [19:0] repeat_buttons,
  output logic [15:0] angle_code,
  output logic [6:0]  stick_magnitude,
  output logic signed [7:0] stick_x,
  output logic signed [7:0] stick_y,
  output logic        home_pressed,
  output logic        hold_active,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gsbq_pkg::*;

  // Configuration registers.
  logic       input_disabled;
  logic [7:0] deadzone_low;
  logic [7:0] deadzone_high;
  logic [3:0] repeat_delay;
  logic [3:0] repeat_reload;

  // Frame-to-frame state.
  logic [19:0] previous_buttons;
  logic [3:0]  held_frames;
  logic        home_latch;
  logic        hold_latch;

  // Per-request working registers, captured when the request is accepted (the magnitude in the prepare state).
  ctl_state_t        state, state_next;
  logic [15:0]       buttons_r;
  logic signed [7:0] sx_r, sy_r;
  logic              zeroed_r;
  logic              deflected_r;
  logic [6:0]        mag_r;

  ang_req_t ang_req;
  ang_rsp_t ang_rsp;

  logic              wr_en;
  logic              accept;
  logic              load;
  logic              hold_next;
  logic              zeroed;
  logic              deflected;
  logic signed [7:0] sx_c, sy_c;
  logic [6:0]        abs_x, abs_y, bmax, bmin;
  logic [7:0]        bmin_scaled;
  logic [8:0]        mag_sum;
  logic [6:0]        mag_c;
  logic [3:0]        dir;
  logic [19:0]       cur, rise, fall, rep;
  logic [4:0]        cnt;
  logic [3:0]        held_next;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high, so there are never wait states. Addresses past the last
  // register write nothing and read as zero.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_disabled <= 1'b0;
      deadzone_low   <= 8'd64;
      deadzone_high  <= 8'd192;
      repeat_delay   <= 4'd12;
      repeat_reload  <= 4'd10;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_INPUT_DISABLED: input_disabled <= pwdata[0];
        REG_DEADZONE_LOW:   deadzone_low   <= pwdata[7:0];
        REG_DEADZONE_HIGH:  deadzone_high  <= pwdata[7:0];
        REG_REPEAT_DELAY:   repeat_delay   <= pwdata[3:0];
        REG_REPEAT_RELOAD:  repeat_reload  <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_INPUT_DISABLED: prdata = {31'd0, input_disabled};
      REG_DEADZONE_LOW:   prdata = {24'd0, deadzone_low};
      REG_DEADZONE_HIGH:  prdata = {24'd0, deadzone_high};
      REG_REPEAT_DELAY:   prdata = {28'd0, repeat_delay};
      REG_REPEAT_RELOAD:  prdata = {28'd0, repeat_reload};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sample qualification at accept time. The hold switch of a valid sample
  // takes effect on that same frame. A zeroed frame (input disabled, hold
  // on, or no sample) reads as released buttons and a centered stick.
  // Centering is raw minus 128, which is the raw value with its top bit
  // flipped; a raw zero is clamped to -127 to keep the axis symmetric.
  // The deadzone test looks at the raw axes, zeroed or not.
  // ---------------------------------------------------------------------
  assign accept    = req_valid & req_ready;
  assign hold_next = sample_valid ? raw_buttons[17] : hold_latch;
  assign zeroed    = input_disabled | hold_next | ~sample_valid;
  assign deflected = (stick_raw_x < deadzone_low) | (stick_raw_x > deadzone_high) |
                     (stick_raw_y < deadzone_low) | (stick_raw_y > deadzone_high);

  always_comb begin
    if (zeroed) begin
      sx_c = '0;
      sy_c = '0;
    end else begin
      sx_c = (stick_raw_x == 8'd0) ? -8'sd127 : signed'({~stick_raw_x[7], stick_raw_x[6:0]});
      sy_c = (stick_raw_y == 8'd0) ? -8'sd127 : signed'({~stick_raw_y[7], stick_raw_y[6:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_latch <= 1'b0;
      hold_latch <= 1'b0;
    end else if (accept && sample_valid) begin
      home_latch <= raw_buttons[16];
      hold_latch <= raw_buttons[17];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buttons_r   <= zeroed ? 16'd0 : raw_buttons[15:0];
      sx_r        <= sx_c;
      sy_r        <= sy_c;
      zeroed_r    <= zeroed;
      deflected_r <= deflected;
    end
  end

  // ---------------------------------------------------------------------
  // Magnitude, computed in the prepare cycle: alpha-max-beta-min with the
  // larger axis scaled by about 0.969 and the smaller by about 0.398,
  // saturated at 127.
  // ---------------------------------------------------------------------
  always_comb begin
    abs_x       = sx_r[7] ? 7'(-sx_r) : sx_r[6:0];
    abs_y       = sy_r[7] ? 7'(-sy_r) : sy_r[6:0];
    bmax        = (abs_x < abs_y) ? abs_y : abs_x;
    bmin        = (abs_x < abs_y) ? abs_x : abs_y;
    bmin_scaled = {1'b0, bmin} + {2'b00, bmin[6:1]};
    mag_sum     = 9'(bmin_scaled[7:6]) + 9'(bmin_scaled[7:2]) + 9'(bmax)
                - 9'(bmax[6:5]);
    mag_c       = (mag_sum > 9'd127) ? 7'd127 : mag_sum[6:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      mag_r <= mag_c;
    end
  end

  // ---------------------------------------------------------------------
  // Angle unit. The angle is forced to zero inside the deadzone and for a
  // centered stick, which also makes the angle code zero.
  // ---------------------------------------------------------------------
  assign ang_req.start  = (state == S_PREP);
  assign ang_req.bypass = ~deflected_r | ((sx_r == 8'sd0) & (sy_r == 8'sd0));
  assign ang_req.sx     = sx_r;
  assign ang_req.sy     = sy_r;

  gsbq_angle u_angle (
    .clk (clk),
    .rst (rst),
    .req (ang_req),
    .rsp (ang_rsp)
  );

  // ---------------------------------------------------------------------
  // Control sequence: sample, prepare, wait for the angle, then load the
  // result register as soon as it is free. The result register lets the
  // next request in while an earlier result waits to be taken.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = S_PREP;
      end
      S_PREP: state_next = S_ANGLE;
      S_ANGLE: begin
        if (ang_rsp.done) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!rsp_valid || rsp_ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Buttons, edges and auto-repeat. Direction bits come from the angle
  // sector, but only for a deflected stick on a frame that was not zeroed.
  // While the combined buttons stay unchanged the held count runs; once it
  // passes the delay, every held bit repeats and the count reloads.
  // ---------------------------------------------------------------------
  always_comb begin
    dir  = (deflected_r && !zeroed_r) ? sector_dir(ang_rsp.sector) : 4'd0;
    cur  = {dir, buttons_r};
    rise = ~previous_buttons & cur;
    fall = previous_buttons & ~cur;
    cnt  = {1'b0, held_frames} + 5'd1;
    if (previous_buttons == cur) begin
      if (cnt > {1'b0, repeat_delay}) begin
        held_next = repeat_reload;
        rep       = cur;
      end else begin
        held_next = cnt[3:0];
        rep       = '0;
      end
    end else begin
      held_next = '0;
      rep       = rise;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
      held_frames      <= '0;
    end else if (load) begin
      previous_buttons <= cur;
      held_frames      <= held_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      combined_buttons <= cur;
      rising_edges     <= rise;
      falling_edges    <= fall;
      repeat_buttons   <= rep;
      angle_code       <= ang_rsp.code;
      stick_magnitude  <= deflected_r ? mag_r : 7'd0;
      stick_x          <= deflected_r ? sx_r : 8'sd0;
      stick_y          <= deflected_r ? sy_r : 8'sd0;
      home_pressed     <= home_latch;
      hold_active      <= hold_latch;
    end
  end

endmodule
